>>> hdl/gkwa_pkg.sv
// Shared types, constants and elaboration-time table functions for the
// Gaussian kernel weighted average block. No dependencies.
`timescale 1ns / 1ps
package gkwa_pkg;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    localparam int IDX_W   = 5;
    localparam int WGT_W   = 32;
    localparam int PH_W    = 18;
    localparam int GATE_W  = 24;
    localparam int SHARP_W = 32;
    localparam int OUT_W   = 32;
    localparam int PSI_W   = 31;

    localparam logic [SHARP_W-1:0] SHARP_RESET = 32'd62980096;
    localparam logic [63:0] ONE_Q30 = 64'd1 << 30;

    typedef struct packed {
        logic                     is_eval;
        logic                     wr_ok;
        logic [IDX_W-1:0]         kernel_index;
        logic signed [WGT_W-1:0]  weight_value;
        logic [PH_W-1:0]          phase;
        logic signed [GATE_W-1:0] gate;
    } item_t;

    function automatic logic [63:0] div_u64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [64:0] r;
        q = '0;
        r = '0;
        for (int b = 63; b >= 0; b--)
        begin
            r = {r[63:0], n[b]};
            if (r >= {1'b0, d})
            begin
                r    = r - {1'b0, d};
                q[b] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] exp_neg_frac(input logic [63:0] x);
        logic signed [63:0] sum;
        logic [63:0] term;
        logic [63:0] k;
        sum  = ONE_Q30;
        term = ONE_Q30;
        for (k = 64'd1; k <= 64'd20; k++)
        begin
            term = (term * x + (ONE_Q30 >> 1)) >> 30;
            term = div_u64(term + (k >> 1), k);
            if (k[0])
            begin
                sum = sum - $signed(term);
            end
            else
            begin
                sum = sum + $signed(term);
            end
        end
        return (sum < 0) ? 64'd0 : sum;
    endfunction

    function automatic logic [63:0] exp_neg_q16(input logic [63:0] t);
        logic [63:0] ip;
        logic [63:0] r;
        logic [63:0] e1;
        logic [63:0] n;
        ip = t >> 16;
        r  = exp_neg_frac((t & 64'hFFFF) << 14);
        e1 = exp_neg_frac(ONE_Q30);
        for (n = 64'd0; n < ip && r != 64'd0; n++)
        begin
            r = (r * e1 + (ONE_Q30 >> 1)) >> 30;
        end
        return r;
    endfunction

endpackage

>>> hdl/gkwa_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps
module gkwa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> hdl/gkwa_front.sv
// Front end: accepts input beats, classifies them and holds them in a
// two-entry queue for the back end. Depends on gkwa_pkg.
`timescale 1ns / 1ps
module gkwa_front
    import gkwa_pkg::*;
#(
    parameter int KERNELS = 32
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [IDX_W-1:0]         kernel_index,
    input  logic signed [WGT_W-1:0]  weight_value,
    input  logic [PH_W-1:0]          phase,
    input  logic signed [GATE_W-1:0] gate,
    output logic                     item_valid,
    input  logic                     item_ready,
    output item_t                    item
);

    item_t      ent_reg [2];
    logic       wp_reg;
    logic       rp_reg;
    logic [1:0] cnt_reg;
    logic [1:0] cnt_next;
    logic       push;
    logic       pop;
    item_t      cls;

    assign in_ready   = (cnt_reg != 2'd2);
    assign item_valid = (cnt_reg != 2'd0);
    assign item       = ent_reg[rp_reg];
    assign push       = in_valid & in_ready;
    assign pop        = item_valid & item_ready;

    always_comb
    begin
        cls.is_eval      = (command == CMD_EVAL);
        cls.wr_ok        = (32'(kernel_index) < KERNELS);
        cls.kernel_index = kernel_index;
        cls.weight_value = weight_value;
        cls.phase        = phase;
        cls.gate         = gate;
        cnt_next         = cnt_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            ent_reg[wp_reg] <= cls;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wp_reg <= ~wp_reg;
            end
            if (pop)
            begin
                rp_reg <= ~rp_reg;
            end
            cnt_reg <= cnt_next;
        end
    end

endmodule

>>> hdl/gkwa_kernel.sv
// Seven-stage kernel activation pipeline: distance, square, sharpness
// product, exp table lookup and interpolation. Depends on gkwa_pkg.
`timescale 1ns / 1ps
module gkwa_kernel
    import gkwa_pkg::*;
#(
    parameter int KERNELS         = 32,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          iss_valid,
    input  logic [$clog2(KERNELS)-1:0]    iss_idx,
    input  logic [PH_W-1:0]               phase,
    input  logic [SHARP_W-1:0]            sharpness,
    output logic                          psi_valid,
    output logic [PSI_W-1:0]              psi
);

    localparam int TW    = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int POS_W = 20 + TW;

    logic [16:0]      ctab [KERNELS];
    logic [PSI_W-1:0] etab [EXP_TABLE_DEPTH + 1];

    for (genvar i = 0; i < KERNELS; i++)
    begin : g_ctr
        localparam int C = (i * 131072 + KERNELS - 1) / (2 * (KERNELS - 1));
        assign ctab[i] = 17'(C);
    end

    for (genvar t = 0; t <= EXP_TABLE_DEPTH; t++)
    begin : g_exp
        localparam logic [63:0] E = exp_neg_q16((64'(t) << 20) / EXP_TABLE_DEPTH);
        assign etab[t] = E[PSI_W-1:0];
    end

    logic [6:0]       v_reg;
    logic [PH_W-1:0]  ad_reg;
    logic [20:0]      d2_reg;
    logic [52:0]      hp_reg;
    logic [19:0]      arg_reg;
    logic             z4_reg;
    logic [PSI_W-1:0] a5_reg;
    logic [PSI_W-1:0] b5_reg;
    logic [19:0]      f5_reg;
    logic             z5_reg;
    logic [50:0]      dp_reg;
    logic [PSI_W-1:0] a6_reg;
    logic             ale6_reg;
    logic             z6_reg;
    logic [PSI_W-1:0] psi_reg;

    logic [PH_W-1:0]  cx;
    logic [PH_W-1:0]  ad;
    logic [36:0]      sq;
    logic [53:0]      argf;
    logic [POS_W-1:0] pos;
    logic [TW-1:0]    idx;
    logic [TW-1:0]    idx1;
    logic [PSI_W-1:0] diff;
    logic [50:0]      dpr;

    always_comb
    begin
        cx   = PH_W'(ctab[iss_idx]);
        ad   = (phase >= cx) ? (phase - cx) : (cx - phase);
        sq   = 37'(ad_reg) * 37'(ad_reg) + 37'd32768;
        argf = 54'(hp_reg) + 54'd32768;
        pos  = POS_W'(arg_reg) * POS_W'(EXP_TABLE_DEPTH);
        idx  = pos[POS_W-1:20];
        idx1 = idx + TW'(1);
        diff = a5_reg - b5_reg;
        dpr  = dp_reg + 51'h80000;
    end

    always_ff @(posedge clk)
    begin
        ad_reg   <= ad;
        d2_reg   <= sq[36:16];
        hp_reg   <= 53'(sharpness) * 53'(d2_reg);
        arg_reg  <= argf[35:16];
        z4_reg   <= |argf[53:36];
        a5_reg   <= etab[idx];
        b5_reg   <= etab[idx1];
        f5_reg   <= pos[19:0];
        z5_reg   <= z4_reg;
        dp_reg   <= 51'(diff) * 51'(f5_reg);
        a6_reg   <= a5_reg;
        ale6_reg <= (a5_reg <= b5_reg);
        z6_reg   <= z5_reg;
        if (z6_reg)
        begin
            psi_reg <= '0;
        end
        else if (ale6_reg)
        begin
            psi_reg <= a6_reg;
        end
        else
        begin
            psi_reg <= a6_reg - dpr[50:20];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            v_reg <= {v_reg[5:0], iss_valid};
        end
    end

    assign psi_valid = v_reg[6];
    assign psi       = psi_reg;

endmodule

>>> hdl/gkwa_div.sv
// Restoring bit-serial divider, one quotient bit per cycle, dividend
// pre-scaled by 2^15. Depends on gkwa_pkg.
`timescale 1ns / 1ps
module gkwa_div
    import gkwa_pkg::*;
#(
    parameter int NUM_W = 54,
    parameter int DEN_W = 36
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [NUM_W-1:0]     num,
    input  logic [DEN_W-1:0]     den,
    output logic                 done,
    output logic [NUM_W+14:0]    quo
);

    localparam int NB   = NUM_W + 15;
    localparam int CN_W = $clog2(NB + 1);

    logic [NB-1:0]    sh_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CN_W-1:0]  cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             ge;
    logic [DEN_W:0]   diffr;

    always_comb
    begin
        trial = {rem_reg, sh_reg[NB-1]};
        ge    = (trial >= {1'b0, den_reg});
        diffr = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= {num, 15'd0};
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            sh_reg  <= {sh_reg[NB-2:0], ge};
            rem_reg <= ge ? diffr[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + CN_W'(1);
                if (cnt_reg == CN_W'(NB - 1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = sh_reg;

endmodule

>>> hdl/gkwa_back.sv
// Back end: executes weight writes and sequences evaluation through the
// kernel pipeline, accumulators, divider, gate scaling and output register.
// Depends on gkwa_pkg, gkwa_ram, gkwa_kernel and gkwa_div.
`timescale 1ns / 1ps
module gkwa_back
    import gkwa_pkg::*;
#(
    parameter int KERNELS         = 32,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    output logic                     item_ready,
    input  item_t                    item,
    input  logic [SHARP_W-1:0]       sharpness,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  force_value,
    output logic                     saturated,
    output logic                     kernel_sum_zero
);

    localparam int KI_W  = $clog2(KERNELS);
    localparam int CNT_W = $clog2(KERNELS + 1);
    localparam int ACC_W = 49 + KI_W;
    localparam int DEN_W = 31 + KI_W;
    localparam int NB    = ACC_W + 15;
    localparam int AXW   = (KI_W > IDX_W) ? KI_W : IDX_W;

    typedef enum logic [7:0] {
        ST_IDLE   = 8'b00000001,
        ST_RUN    = 8'b00000010,
        ST_DSTART = 8'b00000100,
        ST_DIV    = 8'b00001000,
        ST_MUL    = 8'b00010000,
        ST_SUM    = 8'b00100000,
        ST_FIN    = 8'b01000000,
        ST_WAIT   = 8'b10000000
    } state_t;

    state_t                   state_reg, state_next;
    logic [CNT_W-1:0]         iss_cnt_reg;
    logic [CNT_W-1:0]         acc_cnt_reg;
    logic [PH_W-1:0]          phase_reg;
    logic signed [GATE_W-1:0] gate_reg;
    logic [KERNELS-1:0]       wvld_reg;
    logic                     vld1_reg;
    logic signed [WGT_W-1:0]  wpipe_reg [6];
    logic signed [63:0]       p_reg;
    logic                     pv_reg;
    logic [PSI_W-1:0]         psi_d_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [DEN_W-1:0]         den_reg;
    logic [NB-1:0]            q_reg;
    logic [47:0]              plo_reg;
    logic [47:0]              phi_reg;
    logic [71:0]              m_reg;
    logic                     big_reg;
    logic                     neg_reg;
    logic                     szero_reg;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  force_reg;
    logic                     sat_reg;
    logic                     kz_reg;

    logic                     iss_valid;
    logic [KI_W-1:0]          iss_idx;
    logic                     we;
    logic [AXW-1:0]           widx;
    logic [WGT_W-1:0]         rdata;
    logic                     psi_valid;
    logic [PSI_W-1:0]         psi;
    logic                     div_start;
    logic                     div_done;
    logic [NB-1:0]            quo;
    logic [NB:0]              qsum;
    logic signed [31:0]       psi_s;
    logic [63:0]              pm;
    logic [63:0]              pr;
    logic [ACC_W-1:0]         num;
    logic [GATE_W-1:0]        ga;
    logic [71:0]              mr;
    logic [55:0]              magw;
    logic                     sat;
    logic                     load_out;
    logic                     start_eval;

    assign item_ready = (state_reg == ST_IDLE);
    assign start_eval = (state_reg == ST_IDLE) && item_valid && item.is_eval;
    assign we         = (state_reg == ST_IDLE) && item_valid && !item.is_eval && item.wr_ok;
    assign widx       = AXW'(item.kernel_index);
    assign iss_valid  = (state_reg == ST_RUN) && (iss_cnt_reg < CNT_W'(KERNELS));
    assign iss_idx    = iss_cnt_reg[KI_W-1:0];
    assign div_start  = (state_reg == ST_DSTART) && (den_reg != '0);
    assign load_out   = (state_reg == ST_FIN) && (!out_valid_reg || out_ready);

    gkwa_ram #(
        .WIDTH(WGT_W),
        .DEPTH(KERNELS)
    ) u_wram (
        .clk  (clk),
        .we   (we),
        .waddr(widx[KI_W-1:0]),
        .wdata(item.weight_value),
        .raddr(iss_idx),
        .rdata(rdata)
    );

    gkwa_kernel #(
        .KERNELS        (KERNELS),
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_kernel (
        .clk      (clk),
        .rst_n    (rst_n),
        .iss_valid(iss_valid),
        .iss_idx  (iss_idx),
        .phase    (phase_reg),
        .sharpness(sharpness),
        .psi_valid(psi_valid),
        .psi      (psi)
    );

    gkwa_div #(
        .NUM_W(ACC_W),
        .DEN_W(DEN_W)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (num),
        .den  (den_reg),
        .done (div_done),
        .quo  (quo)
    );

    always_comb
    begin
        psi_s = {1'b0, psi};
        pm    = p_reg[63] ? (64'd0 - p_reg) : p_reg;
        pr    = (pm + 64'h2000) >> 14;
        num   = acc_reg[ACC_W-1] ? (ACC_W'(0) - acc_reg) : acc_reg;
        qsum  = {1'b0, quo} + (NB + 1)'(1);
        ga    = gate_reg[GATE_W-1] ? (GATE_W'(0) - gate_reg) : gate_reg;
        mr    = m_reg + 72'd32768;
        magw  = mr[71:16];
        sat   = big_reg || (!neg_reg && magw > 56'h7FFFFFFF)
                || (neg_reg && magw > 56'h80000000);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start_eval)
                begin
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (pv_reg && acc_cnt_reg == CNT_W'(KERNELS - 1))
                begin
                    state_next = ST_WAIT;
                end
            end
            ST_WAIT:
            begin
                state_next = ST_DSTART;
            end
            ST_DSTART:
            begin
                state_next = (den_reg == '0) ? ST_FIN : ST_DIV;
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (start_eval)
        begin
            phase_reg <= item.phase;
            gate_reg  <= item.gate;
        end
        vld1_reg     <= wvld_reg[iss_idx];
        wpipe_reg[0] <= vld1_reg ? $signed(rdata) : '0;
        for (int k = 1; k < 6; k++)
        begin
            wpipe_reg[k] <= wpipe_reg[k-1];
        end
        p_reg     <= psi_s * wpipe_reg[5];
        psi_d_reg <= psi;
        if (start_eval)
        begin
            acc_reg <= '0;
            den_reg <= '0;
        end
        else if (pv_reg)
        begin
            if (p_reg[63])
            begin
                acc_reg <= acc_reg - $signed(ACC_W'(pr));
            end
            else
            begin
                acc_reg <= acc_reg + $signed(ACC_W'(pr));
            end
            den_reg <= den_reg + DEN_W'(psi_d_reg);
        end
        if (state_reg == ST_DSTART)
        begin
            szero_reg <= (den_reg == '0);
            m_reg     <= '0;
            big_reg   <= 1'b0;
        end
        if (state_reg == ST_DIV && div_done)
        begin
            q_reg <= qsum[NB:1];
        end
        if (state_reg == ST_MUL)
        begin
            plo_reg <= 48'(q_reg[23:0]) * 48'(ga);
            phi_reg <= 48'(q_reg[47:24]) * 48'(ga);
            big_reg <= (|q_reg[NB-1:48]) && (gate_reg != '0);
            neg_reg <= acc_reg[ACC_W-1] ^ gate_reg[GATE_W-1];
        end
        if (state_reg == ST_SUM)
        begin
            m_reg <= 72'(plo_reg) + {phi_reg, 24'd0};
        end
        if (load_out)
        begin
            kz_reg  <= szero_reg;
            sat_reg <= sat;
            if (sat)
            begin
                force_reg <= neg_reg ? 32'sh80000000 : 32'sh7FFFFFFF;
            end
            else
            begin
                force_reg <= neg_reg ? $signed(32'd0 - magw[31:0]) : $signed(magw[31:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            iss_cnt_reg   <= '0;
            acc_cnt_reg   <= '0;
            wvld_reg      <= '0;
            pv_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pv_reg    <= psi_valid;
            if (start_eval)
            begin
                iss_cnt_reg <= '0;
                acc_cnt_reg <= '0;
            end
            else
            begin
                if (iss_valid)
                begin
                    iss_cnt_reg <= iss_cnt_reg + CNT_W'(1);
                end
                if (pv_reg)
                begin
                    acc_cnt_reg <= acc_cnt_reg + CNT_W'(1);
                end
            end
            if (we)
            begin
                wvld_reg[widx[KI_W-1:0]] <= 1'b1;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign force_value     = force_reg;
    assign saturated       = sat_reg;
    assign kernel_sum_zero = kz_reg;

endmodule

>>> hdl/gaussian_kernel_weighted_average_top.sv
// Evaluate: one kernel per cycle through the activation pipeline, then a
// one-bit-per-cycle divider.
// Items are taken one at a time by the back end; a two-beat
// queue and the output register let input and output stall independently.
// Reset (async, active low) clears the weights to zero and sets sharpness to 961.0.
`timescale 1ns / 1ps
module gaussian_kernel_weighted_average_top
    import gkwa_pkg::*;
#(
    parameter int KERNELS         = 32,
    parameter int EXP_TABLE_DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_ready,
    input  logic                     command,
    input  logic [IDX_W-1:0]         kernel_index,
    input  logic signed [WGT_W-1:0]  weight_value,
    input  logic [PH_W-1:0]          phase,
    input  logic signed [GATE_W-1:0] gate,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic signed [OUT_W-1:0]  force_value,
    output logic                     saturated,
    output logic                     kernel_sum_zero,
    input  logic                     cfg_valid,
    output logic                     cfg_ready,
    input  logic [SHARP_W-1:0]       cfg_data
);

    logic [SHARP_W-1:0] sharp_reg;
    logic               item_valid;
    logic               item_ready;
    item_t              item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sharp_reg <= SHARP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            sharp_reg <= cfg_data;
        end
    end

    gkwa_front #(
        .KERNELS(KERNELS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .kernel_index(kernel_index),
        .weight_value(weight_value),
        .phase       (phase),
        .gate        (gate),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item)
    );

    gkwa_back #(
        .KERNELS        (KERNELS),
        .EXP_TABLE_DEPTH(EXP_TABLE_DEPTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item_ready     (item_ready),
        .item           (item),
        .sharpness      (sharp_reg),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .force_value    (force_value),
        .saturated      (saturated),
        .kernel_sum_zero(kernel_sum_zero)
    );

endmodule

>>> hdl/gkwa_checker.sv
// Port-level checker for the top level and its bind statement.
// Depends on gkwa_pkg and gaussian_kernel_weighted_average_top.
`timescale 1ns / 1ps
module gkwa_props
    import gkwa_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic signed [OUT_W-1:0]  force_value,
    input logic                     saturated,
    input logic                     kernel_sum_zero
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(force_value))
        else $error("Result beat changed while stalled.");

    a_zero_sum: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kernel_sum_zero |-> force_value == '0 && !saturated)
        else $error("Zero kernel sum must give a clean zero result.");

    a_sat_clip: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && saturated
        |-> force_value == 32'sh7FFFFFFF || force_value == 32'sh80000000)
        else $error("Saturated result is not at a range limit.");

endmodule

bind gaussian_kernel_weighted_average_top gkwa_props u_gkwa_props (.*);
